// ===== rtl/core/packed_pixel_clut_decoder_assert.svh =====
// Assertion macros shared by the decoder's queue and pixel engine.
// Expects clk and arst_n in the scope of each use.
`ifndef PACKED_PIXEL_CLUT_DECODER_ASSERT_SVH
`define PACKED_PIXEL_CLUT_DECODER_ASSERT_SVH

// same-cycle implication
`define PPCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ppcd_pkg.sv =====
// Shared types, codes and constants for the packed-pixel colour-table decoder.
// No dependencies.
`default_nettype none

package ppcd_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int MAX_WIDTH     = 2048;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [11:0] COL_MAX       = 12'hFFF;
	localparam logic [11:0] ROW_WIDTH_RST = 12'd640;

	typedef enum logic [2:0] {
		DM_1BPP   = 3'd0,
		DM_2BPP   = 3'd1,
		DM_4BPP   = 3'd2,
		DM_8BPP   = 3'd3,
		DM_RGB555 = 3'd4,
		DM_XRGB   = 3'd5
	} depth_t;

	typedef enum logic {
		REG_DEPTH = 1'b0,
		REG_WIDTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_TWRITE = 2'd0,
		OP_LUT    = 2'd1,
		OP_DIRECT = 2'd2,
		OP_MARK   = 2'd3
	} op_kind_t;

	typedef enum logic [1:0] {
		BPP1 = 2'd0,
		BPP2 = 2'd1,
		BPP4 = 2'd2,
		BPP8 = 2'd3
	} bpp_t;

	typedef struct packed {
		op_kind_t    kind;
		bpp_t        bpp;
		logic [7:0]  data8;
		logic [23:0] rgb;
		logic        row_end;
	} op_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  vram_byte;
		logic        row_end;
		logic [7:0]  table_index;
		logic [23:0] table_rgb;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_rgb;
		logic [10:0] pixel_x;
		logic        row_last;
	} out_item_t;

	function automatic logic [23:0] rgb555_expand(input logic [15:0] p);
		return {p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000};
	endfunction

	function automatic logic [2:0] slot_last(input bpp_t bpp);
		logic [2:0] r;
		unique case (bpp)
			BPP1:    r = 3'd7;
			BPP2:    r = 3'd3;
			BPP4:    r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// colour index of one slot, most significant bits first
	function automatic logic [7:0] slot_index(input logic [7:0] b, input bpp_t bpp,
			input logic [2:0] slot);
		logic [3:0] amt;
		logic [7:0] sh;
		logic [7:0] r;
		unique case (bpp)
			BPP1:    amt = {1'b0, slot};
			BPP2:    amt = {1'b0, slot[1:0], 1'b0};
			BPP4:    amt = {1'b0, slot[0], 2'b00};
			default: amt = 4'd0;
		endcase
		sh = 8'(b << amt);
		unique case (bpp)
			BPP1:    r = {7'b0, sh[7]};
			BPP2:    r = {6'b0, sh[7:6]};
			BPP4:    r = {4'b0, sh[7:4]};
			default: r = sh;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/packed_pixel_clut_decoder.sv =====
// Packed-pixel colour-table decoder: top level with configuration registers.
// Depends on ppcd_pkg, ppcd_front, ppcd_fifo and ppcd_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one beat per video memory
//   byte or colour table write. Output channel (out_valid/out_ready/out_data)
//   carries one pixel per beat with its column and a last-visible flag.
//   Configuration (cfg_write/cfg_index/cfg_data) sets depth and row width; write
//   it only while no beat is in flight.
//   A four-entry operation queue sits between the byte front end and the pixel
//   engine, whose pixels are registered at the output. Throughput: the engine
//   issues one pixel or one table write per cycle while its output is not
//   stalled, a byte yielding 8, 4, 2 or 1 pixels at 1, 2, 4 and 8 bpp; 16 and
//   24 bpp take one input beat per cycle while the queue has room.
//   Reset: depth 1 bpp, width 640, column and byte assembly cleared; table
//   contents stay undefined until written.
//   Receiver stall: the output register holds its pixel, the engine halts at its
//   next pixel operation, the queue fills and then in_ready drops.
`default_nettype none

module packed_pixel_clut_decoder #(
	parameter int TABLE_ENTRIES = ppcd_pkg::TABLE_ENTRIES,
	parameter int QUEUE_DEPTH   = ppcd_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire ppcd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output ppcd_pkg::out_item_t      out_data,
	input  wire logic                cfg_write,
	input  wire logic                cfg_index,
	input  wire logic [11:0]         cfg_data
);

	ppcd_pkg::depth_t depth_q;
	logic [11:0]      width_q;
	logic             depth_wr, accept, push, pop, full, head_valid;
	ppcd_pkg::op_t    push_op, head_op;

	assign depth_wr = cfg_write && (cfg_index == ppcd_pkg::REG_DEPTH);
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= ppcd_pkg::DM_1BPP;
			width_q <= ppcd_pkg::ROW_WIDTH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ppcd_pkg::REG_DEPTH: depth_q <= ppcd_pkg::depth_t'(cfg_data[2:0]);
				default:             width_q <= cfg_data;
			endcase
		end
	end

	ppcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (in_data),
		.depth_mode (depth_q),
		.depth_wr   (depth_wr),
		.push       (push),
		.push_op    (push_op)
	);

	ppcd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	ppcd_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_width  (width_q),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/ppcd_front.sv =====
// Front end: accepts input beats, assembles 16/24 bpp pixels, classifies operations.
// Depends on ppcd_pkg.
`default_nettype none

module ppcd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire ppcd_pkg::in_item_t item,
	input  wire ppcd_pkg::depth_t  depth_mode,
	input  wire logic              depth_wr,
	output logic                   push,
	output ppcd_pkg::op_t          push_op
);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] part_q, part_d;
	logic        push_w;

	always_comb begin
		push_w           = 1'b0;
		push_op.kind     = ppcd_pkg::OP_MARK;
		push_op.bpp      = ppcd_pkg::BPP8;
		push_op.data8    = item.vram_byte;
		push_op.rgb      = '0;
		push_op.row_end  = item.row_end;
		phase_d          = phase_q;
		part_d           = part_q;
		if (item.cmd) begin
			push_op.kind    = ppcd_pkg::OP_TWRITE;
			push_op.data8   = item.table_index;
			push_op.rgb     = item.table_rgb;
			push_op.row_end = 1'b0;
			push_w          = 1'b1;
		end else begin
			unique case (depth_mode)
				ppcd_pkg::DM_1BPP: begin
					push_op.kind = ppcd_pkg::OP_LUT;
					push_op.bpp  = ppcd_pkg::BPP1;
					push_w       = 1'b1;
				end
				ppcd_pkg::DM_2BPP: begin
					push_op.kind = ppcd_pkg::OP_LUT;
					push_op.bpp  = ppcd_pkg::BPP2;
					push_w       = 1'b1;
				end
				ppcd_pkg::DM_4BPP: begin
					push_op.kind = ppcd_pkg::OP_LUT;
					push_op.bpp  = ppcd_pkg::BPP4;
					push_w       = 1'b1;
				end
				ppcd_pkg::DM_RGB555: begin
					if (phase_q == 2'd0) begin
						part_d  = {8'b0, item.vram_byte};
						phase_d = 2'd1;
					end else begin
						push_op.kind = ppcd_pkg::OP_DIRECT;
						push_op.rgb  = ppcd_pkg::rgb555_expand({part_q[7:0], item.vram_byte});
						push_w       = 1'b1;
						phase_d      = 2'd0;
						part_d       = '0;
					end
				end
				ppcd_pkg::DM_XRGB: begin
					if (phase_q == 2'd0) begin
						part_d  = '0;
						phase_d = 2'd1;
					end else if (phase_q != 2'd3) begin
						part_d  = {part_q[7:0], item.vram_byte};
						phase_d = phase_q + 2'd1;
					end else begin
						push_op.kind = ppcd_pkg::OP_DIRECT;
						push_op.rgb  = {part_q, item.vram_byte};
						push_w       = 1'b1;
						phase_d      = 2'd0;
						part_d       = '0;
					end
				end
				default: begin
					push_op.kind = ppcd_pkg::OP_LUT;
					push_op.bpp  = ppcd_pkg::BPP8;
					push_w       = 1'b1;
				end
			endcase
			if (item.row_end) begin
				phase_d = 2'd0;
				part_d  = '0;
				push_w  = 1'b1;
			end
		end
	end

	assign push = accept && push_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			part_q  <= '0;
		end else if (depth_wr) begin
			phase_q <= '0;
			part_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			part_q  <= part_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ppcd_fifo.sv =====
// Short operation queue between the front end and the pixel engine.
// Depends on ppcd_pkg and the assertion macro header.
`default_nettype none

module ppcd_fifo #(
	parameter int DEPTH = ppcd_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ppcd_pkg::op_t push_op,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output ppcd_pkg::op_t      head_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	ppcd_pkg::op_t  slots_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_op    = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`include "packed_pixel_clut_decoder_assert.svh"

	`PPCD_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue overflow")
	`PPCD_ASSERT_NOW(a_no_underflow, pop, head_valid, "queue underflow")
	`PPCD_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

// ===== rtl/core/ppcd_back.sv =====
// Pixel engine: colour table, column tracking and registered pixel output.
// Depends on ppcd_pkg and the assertion macro header.
`default_nettype none

module ppcd_back #(
	parameter int TABLE_ENTRIES = ppcd_pkg::TABLE_ENTRIES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [11:0]   row_width,
	input  wire logic          head_valid,
	input  wire ppcd_pkg::op_t head_op,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ppcd_pkg::out_item_t out_data
);

	localparam int TAW = $clog2(TABLE_ENTRIES);
	localparam logic [8:0]  TBL_LIMIT = 9'(TABLE_ENTRIES);
	localparam logic [12:0] VIS_MAX   = 13'(ppcd_pkg::MAX_WIDTH);

	logic [23:0]    mem [TABLE_ENTRIES];
	logic [23:0]    rd_q, direct_q;
	logic           from_lut_q, lut_ok_q, last_q, out_valid_q;
	logic [10:0]    x_q;
	logic [11:0]    col_q;
	logic [2:0]     slot_q;

	logic [12:0]    vis;
	logic           is_pix, advance, step, is_last, emit, visible, row_last_w;
	logic [7:0]     lut_idx;
	logic           lut_ok, wr_ok, wr_en;

	assign vis = ({1'b0, row_width} > VIS_MAX) ? VIS_MAX : {1'b0, row_width};

	assign is_pix  = head_valid && (head_op.kind == ppcd_pkg::OP_LUT ||
		head_op.kind == ppcd_pkg::OP_DIRECT);
	assign advance = !out_valid_q || out_ready;
	assign step    = head_valid && (!is_pix || advance);
	assign is_last = (head_op.kind != ppcd_pkg::OP_LUT) ||
		(slot_q == ppcd_pkg::slot_last(head_op.bpp));
	assign pop     = step && is_last;
	assign emit    = step && is_pix;

	assign visible    = ({1'b0, col_q} < vis);
	assign row_last_w = (({1'b0, col_q} + 13'd1) == vis);

	assign lut_idx = ppcd_pkg::slot_index(head_op.data8, head_op.bpp, slot_q);
	assign lut_ok  = ({1'b0, lut_idx} < TBL_LIMIT);
	assign wr_ok   = ({1'b0, head_op.data8} < TBL_LIMIT);
	assign wr_en   = step && head_op.kind == ppcd_pkg::OP_TWRITE && wr_ok;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_op.data8[TAW-1:0]] <= head_op.rgb;
		end
		if (emit) begin
			rd_q       <= mem[lut_idx[TAW-1:0]];
			lut_ok_q   <= lut_ok;
			from_lut_q <= (head_op.kind == ppcd_pkg::OP_LUT);
			direct_q   <= head_op.rgb;
			x_q        <= col_q[10:0];
			last_q     <= row_last_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
			slot_q      <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= visible;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && head_op.row_end) begin
				col_q <= '0;
			end else if (emit && col_q != ppcd_pkg::COL_MAX) begin
				col_q <= col_q + 12'd1;
			end
			if (step && head_op.kind == ppcd_pkg::OP_LUT) begin
				slot_q <= is_last ? 3'd0 : slot_q + 3'd1;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_data.pixel_rgb = from_lut_q ? (lut_ok_q ? rd_q : 24'd0) : direct_q;
	assign out_data.pixel_x   = x_q;
	assign out_data.row_last  = last_q;

`include "packed_pixel_clut_decoder_assert.svh"

	`PPCD_ASSERT_NOW(a_slot_idle, head_valid && head_op.kind != ppcd_pkg::OP_LUT, slot_q == 3'd0, "slot counter left running")
	`PPCD_ASSERT_NEXT(a_row_reset, pop && head_op.row_end, col_q == 12'd0, "column not cleared at row end")
	`PPCD_ASSERT_NOW(a_pixel_source, $rose(out_valid_q), $past(head_valid), "pixel without operation")

endmodule

`default_nettype wire
